// ----- design/fsnc_pkg.sv -----
// Package for the FAT short-name checker: lane flag struct, character
// constants and the two reserved OS/2 extended-attribute names.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsnc_pkg;

    localparam int NAME_BYTES = 11;
    localparam int BASE_BYTES = 8;
    localparam int EXT_BYTES  = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Reserved OS/2 names, first character at index 0.
    localparam logic [7:0] OS2_EA_DATA [NAME_BYTES] = '{
        8'h45, 8'h41, 8'h20, 8'h44, 8'h41, 8'h54, 8'h41, 8'h20, 8'h20, 8'h53, 8'h46
    };
    localparam logic [7:0] OS2_WP_ROOT [NAME_BYTES] = '{
        8'h57, 8'h50, 8'h20, 8'h52, 8'h4F, 8'h4F, 8'h54, 8'h20, 8'h20, 8'h53, 8'h46
    };

    // What one byte lane reports about its character.
    typedef struct packed {
        logic bad;     // control byte, DEL or forbidden character
        logic high;    // byte above 0x7F
        logic space;   // byte is a space
        logic ea_eq;   // matches the extended-attribute data name here
        logic wp_eq;   // matches the workplace root name here
    } t_lane_flags;

    // Characters forbidden under both rule sets, and those only outside GEMDOS.
    function automatic logic forbidden_char(input logic [7:0] c, input logic gemdos);
        logic common;
        logic extra;
        common = (c == 8'h2A) || (c == 8'h3F) || (c == 8'h5C) || (c == 8'h2F)
              || (c == 8'h3A);
        extra  = (c == 8'h3C) || (c == 8'h3E) || (c == 8'h7C) || (c == 8'h22);
        return common || (!gemdos && extra);
    endfunction

endpackage

`default_nettype wire

// ----- design/fsnc_lane.sv -----
// One byte lane of the short-name checker: classifies a single name byte.
// Depends on fsnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsnc_lane #(
    parameter int LANE_IDX = 0
) (
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_atari,
    output fsnc_pkg::t_lane_flags     o_flags
);
    import fsnc_pkg::*;

    always_comb begin
        o_flags.bad   = (i_byte < CH_SPACE) || (i_byte == CH_DEL)
                      || forbidden_char(i_byte, i_atari);
        o_flags.high  = i_byte[7];
        o_flags.space = (i_byte == CH_SPACE);
        o_flags.ea_eq = (i_byte == OS2_EA_DATA[LANE_IDX]);
        o_flags.wp_eq = (i_byte == OS2_WP_ROOT[LANE_IDX]);
    end

endmodule

`default_nettype wire

// ----- design/fsnc_merge.sv -----
// Merging stage of the short-name checker: combines the eleven lane flags
// with the entry flags into the verdict. Depends on fsnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsnc_merge (
    input  wire fsnc_pkg::t_lane_flags i_flags [fsnc_pkg::NAME_BYTES],
    input  wire logic                  i_has_long_name,
    input  wire logic                  i_short_name_absent,
    input  wire logic                  i_atari,
    output logic                       o_name_bad
);
    import fsnc_pkg::*;

    logic ea_match;
    logic wp_match;
    logic any_bad;
    logic any_high;
    logic base_gap;
    logic ext_gap;
    logic seen_space;

    always_comb begin
        ea_match = 1'b1;
        wp_match = 1'b1;
        any_bad  = 1'b0;
        any_high = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            ea_match = ea_match & i_flags[i].ea_eq;
            wp_match = wp_match & i_flags[i].wp_eq;
            any_bad  = any_bad  | i_flags[i].bad;
            any_high = any_high | i_flags[i].high;
        end

        // A gap is a non-space after a space in the same part of the name.
        base_gap   = 1'b0;
        seen_space = 1'b0;
        for (int i = 0; i < BASE_BYTES; i++) begin
            base_gap   = base_gap | (seen_space & ~i_flags[i].space);
            seen_space = seen_space | i_flags[i].space;
        end
        ext_gap    = 1'b0;
        seen_space = 1'b0;
        for (int i = BASE_BYTES; i < NAME_BYTES; i++) begin
            ext_gap    = ext_gap | (seen_space & ~i_flags[i].space);
            seen_space = seen_space | i_flags[i].space;
        end

        if (ea_match || wp_match) begin
            o_name_bad = 1'b0;
        end else if (i_short_name_absent) begin
            o_name_bad = ~i_has_long_name;
        end else begin
            o_name_bad = any_bad | base_gap | ext_gap | (i_atari & any_high);
        end
    end

endmodule

`default_nettype wire

// ----- design/fat_short_name_checker_core.sv -----
// An entry's lane flags are registered in stage one and its verdict in stage two.
// Throughput: one directory entry per cycle while the master side accepts results;
// stage one holds the eleven byte-lane flags, stage two is the output register, and
// an entry is taken whenever stage one is empty or moving on.
// Reset (synchronous, active low) empties both stages and clears the Atari mode bit.
`timescale 1ns / 1ps
`default_nettype none

module fat_short_name_checker_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,   // atari_mode
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [87:0] i_s_tdata,       // base_name [63:0], extension [87:64]
    input  wire logic [1:0]  i_s_tuser,       // has_long_name [0], short_name_absent [1]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata        // name_bad [0], zero fill [7:1]
);
    import fsnc_pkg::*;

    logic        r_atari;
    t_lane_flags lane_flags [NAME_BYTES];
    t_lane_flags r_s1_flags [NAME_BYTES];
    logic [1:0]  r_s1_user;
    logic        r_s1_valid;
    logic        r_out_valid;
    logic        r_out_bad;
    logic        merge_bad;
    logic        out_ready;
    logic        s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atari <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_atari <= i_cfg_wr_data;
        end
    end

    for (genvar g = 0; g < NAME_BYTES; g++) begin : g_lane
        fsnc_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_byte  (i_s_tdata[8*g +: 8]),
            .i_atari (r_atari),
            .o_flags (lane_flags[g])
        );
    end

    assign out_ready  = ~r_out_valid | i_m_tready;
    assign o_s_tready = ~r_s1_valid | out_ready;
    assign s1_load    = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_flags <= lane_flags;
            r_s1_user  <= i_s_tuser;
        end
    end

    fsnc_merge u_merge (
        .i_flags             (r_s1_flags),
        .i_has_long_name     (r_s1_user[0]),
        .i_short_name_absent (r_s1_user[1]),
        .i_atari             (r_atari),
        .o_name_bad          (merge_bad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out_bad <= merge_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_bad};

endmodule

`default_nettype wire

// ----- design/fsnc_checker.sv -----
// Port-level checker for the FAT short-name checker, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module fsnc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata
);

    // A stalled result transaction keeps its valid and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result transaction changed while stalled");

    // The input side only stalls when a result is waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a waiting result");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    // The verdict occupies bit 0 only.
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'd0))
        else $error("fill bits of result data not zero");

endmodule

bind fat_short_name_checker_core fsnc_checker u_fsnc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ----- sim/fat_short_name_checker_core_tb.sv -----
// Self-checking testbench for fat_short_name_checker_core: directed and random
// 8.3 names in both rule sets, with the verdicts predicted inside the bench.
// Depends only on the RTL of the core.
`timescale 1ns / 1ps

module fat_short_name_checker_core_tb;

    localparam int CYCLE_LIMIT = 600000;

    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_DEL   = 8'h7F;
    // The two OS/2 extended-attribute names, first character in the lowest byte.
    localparam logic [63:0] EA_DATA_BASE = 64'h2041_5441_4420_4145;
    localparam logic [63:0] WP_ROOT_BASE = 64'h2054_4F4F_5220_5057;
    localparam logic [23:0] OS2_EA_EXT   = 24'h46_5320;

    typedef struct packed {
        logic [63:0] base;
        logic [23:0] ext;
        logic        long_name;
        logic        absent;
    } t_entry;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_s_tvalid    = 1'b0;
    logic [87:0] i_s_tdata     = '0;    // base_name [63:0], extension [87:64]
    logic [1:0]  i_s_tuser     = '0;    // has_long_name [0], short_name_absent [1]
    logic        i_m_tready    = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [7:0]  o_m_tdata;             // name_bad [0], zero fill [7:1]

    t_entry entries_to_send[$];
    logic   verdicts_due[$];
    t_entry offered_entry = '0;
    logic   atari_sel     = 1'b0;
    bit     steady_flow   = 1'b0;
    logic   hold_request  = 1'b0;
    logic   held_once     = 1'b0;
    int     hold_left     = 0;
    int     stall_left    = 0;
    int     gap_left      = 0;
    int     mismatches    = 0;
    int     cycle_count   = 0;

    fat_short_name_checker_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_forbidden(input logic [7:0] c, input logic gemdos);
        case (c)
            "*", "?", "\\", "/", ":": return 1'b1;
            "<", ">", "|", "\"":      return !gemdos;
            default:                  return 1'b0;
        endcase
    endfunction

    // Verdict for one directory entry under the given rule set; 1 means bad.
    function automatic logic short_name_bad(input t_entry e, input logic gemdos);
        logic [7:0] ch [11];
        logic       high_seen;
        logic       space_seen;
        int         i;
        for (i = 0; i < 8; i++) ch[i] = e.base[8*i +: 8];
        for (i = 0; i < 3; i++) ch[8+i] = e.ext[8*i +: 8];
        if (e.ext == OS2_EA_EXT && (e.base == EA_DATA_BASE || e.base == WP_ROOT_BASE))
            return 1'b0;
        if (e.absent)
            return !e.long_name;
        high_seen = 1'b0;
        for (i = 0; i < 11; i++) begin
            if (ch[i] < CH_SPACE || ch[i] == CH_DEL || is_forbidden(ch[i], gemdos))
                return 1'b1;
            if (ch[i] > CH_DEL)
                high_seen = 1'b1;
        end
        // Once a space has been seen, only spaces may follow in the same part.
        space_seen = 1'b0;
        for (i = 0; i < 11; i++) begin
            if (i == 8)
                space_seen = 1'b0;
            if (ch[i] == CH_SPACE)
                space_seen = 1'b1;
            else if (space_seen)
                return 1'b1;
        end
        return gemdos && high_seen;
    endfunction

    function automatic t_entry make_entry(input string name11, input logic ln, input logic ab,
                                          input int pos, input logic [7:0] patch);
        t_entry e;
        int     i;
        for (i = 0; i < 8; i++) e.base[8*i +: 8] = name11[i];
        for (i = 0; i < 3; i++) e.ext[8*i +: 8] = name11[8+i];
        if (pos >= 0 && pos < 8)
            e.base[8*pos +: 8] = patch;
        else if (pos >= 8)
            e.ext[8*(pos-8) +: 8] = patch;
        e.long_name = ln;
        e.absent    = ab;
        return e;
    endfunction

    function automatic t_entry random_entry();
        t_entry     e;
        logic [7:0] ch [11];
        int         kind;
        int         blen;
        int         elen;
        int         pos;
        int         r;
        int         i;
        string      legal_syms;
        string      reject_syms;
        legal_syms  = "!#$%&'()-@^_{}~";
        reject_syms = "*?\\/:<>|\"";
        e.long_name = 1'($urandom_range(0, 1));
        e.absent    = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            e.base   = {$urandom, $urandom};
            e.ext    = 24'($urandom);
            e.absent = 1'($urandom_range(0, 1));
            return e;
        end
        if (kind < 25) begin
            e.base   = $urandom_range(0, 1) ? EA_DATA_BASE : WP_ROOT_BASE;
            e.ext    = OS2_EA_EXT;
            e.absent = 1'($urandom_range(0, 1));
            // Near misses: one bit off a reserved name.
            if ($urandom_range(0, 2) == 0)
                {e.base, e.ext} = {e.base, e.ext} ^ (88'd1 << $urandom_range(0, 87));
            return e;
        end
        // A well-formed name, padded with spaces, then perhaps one faulty byte.
        blen = $urandom_range(1, 8);
        elen = $urandom_range(0, 3);
        for (i = 0; i < 11; i++) begin
            if (i < blen || (i >= 8 && i - 8 < elen)) begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    ch[i] = 8'($urandom_range(8'h41, 8'h5A));
                else if (r < 8)
                    ch[i] = 8'($urandom_range(8'h30, 8'h39));
                else if (r == 8)
                    ch[i] = legal_syms[$urandom_range(0, legal_syms.len() - 1)];
                else
                    ch[i] = 8'($urandom_range(8'h80, 8'hFF));
            end else begin
                ch[i] = CH_SPACE;
            end
        end
        if ($urandom_range(0, 9) < 4) begin
            pos = $urandom_range(0, 10);
            case ($urandom_range(0, 4))
                0: ch[pos] = 8'($urandom_range(0, 31));
                1: ch[pos] = CH_DEL;
                2: ch[pos] = reject_syms[$urandom_range(0, reject_syms.len() - 1)];
                3: ch[pos] = CH_SPACE;
                default: ch[pos] = 8'($urandom_range(0, 255));
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            e.absent = 1'b1;
        for (i = 0; i < 8; i++) e.base[8*i +: 8] = ch[i];
        for (i = 0; i < 3; i++) e.ext[8*i +: 8] = ch[8+i];
        return e;
    endfunction

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // The names whose verdict depends on the rule set come first.
    task automatic load_directed(input int count);
        t_entry list[$];
        int     i;
        list.push_back(make_entry("ABCDEFGHIJK", 1'b0, 1'b0, 0, 8'h80));
        list.push_back({{88{1'b1}}, 2'b00});
        list.push_back(make_entry("FILE<   TXT", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("A|B     TXT", 1'b1, 1'b0, -1, 8'h00));
        list.push_back(make_entry("QUOTE   \"  ", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("STAR*   TXT", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("DIR     C:X", 1'b0, 1'b0, -1, 8'h00));
        list.push_back('0);
        list.push_back({{88{1'b1}}, 2'b11});
        list.push_back(make_entry("EA DATA  SF", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("WP ROOT  SF", 1'b0, 1'b1, -1, 8'h00));
        list.push_back(make_entry("FOO     TXT", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("FOO     TXT", 1'b0, 1'b1, -1, 8'h00));
        list.push_back(make_entry("FOO     TXT", 1'b1, 1'b1, -1, 8'h00));
        list.push_back(make_entry("FOO     TXT", 1'b0, 1'b0, 7, 8'h1F));
        list.push_back(make_entry("FOO     TXT", 1'b0, 1'b0, 10, CH_DEL));
        list.push_back(make_entry("A B     TXT", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("FOO      TX", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("           ", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("FOO     T  ", 1'b1, 1'b0, -1, 8'h00));
        list.push_back(make_entry("FOO\\    TXT", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("FOO/    TXT", 1'b0, 1'b0, -1, 8'h00));
        list.push_back(make_entry("WHAT?   TXT", 1'b0, 1'b0, -1, 8'h00));
        for (i = 0; i < count && i < list.size(); i++)
            entries_to_send.push_back(list[i]);
    endtask

    task automatic load_random(input int count);
        repeat (count) entries_to_send.push_back(random_entry());
    endtask

    // Waits until every entry has been sent and every verdict has come back.
    task automatic drain();
        while (entries_to_send.size() != 0 || i_s_tvalid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_atari(input logic mode);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
        atari_sel = mode;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_atari(1'b0);
        load_directed(100);
        drain();
        set_atari(1'b1);
        load_directed(7);
        drain();

        // The receiver holds off for a long stretch early in this phase.
        set_atari(1'b1);
        hold_request = 1'b1;
        load_random(300);
        drain();
        set_atari(1'b0);
        steady_flow = 1'b1;
        load_random(300);
        drain();
        steady_flow = 1'b0;
        set_atari(1'b1);
        load_random(275);
        drain();
        set_atari(1'b0);
        load_random(275);
        drain();

        if (mismatches == 0)
            $display("[fat_short_name_checker_core] OK");
        else
            $display("[fat_short_name_checker_core] ERROR");
        $finish;
    end

    // Sender: holds each transaction until it is taken, then waits a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_left   <= 0;
        end else if (i_s_tvalid && !o_s_tready) begin
            i_s_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            i_s_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
        end else if (entries_to_send.size() != 0) begin
            offered_entry <= entries_to_send[0];
            i_s_tdata     <= {entries_to_send[0].ext, entries_to_send[0].base};
            i_s_tuser     <= {entries_to_send[0].absent, entries_to_send[0].long_name};
            i_s_tvalid    <= 1'b1;
            gap_left      <= pick_gap();
            void'(entries_to_send.pop_front());
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Receiver readiness, with one long hold-off so that the core fills up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            held_once  <= 1'b0;
        end else if (hold_request && !held_once) begin
            i_m_tready <= 1'b0;
            hold_left  <= 150;
            held_once  <= 1'b1;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Records the verdict for each accepted entry and checks each result in order.
    always @(posedge i_clk) begin : check_results
        logic want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                verdicts_due.push_back(short_name_bad(offered_entry, atari_sel));
            if (o_m_tvalid && i_m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_tdata);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_m_tdata !== {7'b0, want}) begin
                        $display("%0t: name_bad mismatch, expected %h, actual %h",
                                 $time, {7'b0, want}, o_m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[fat_short_name_checker_core] ERROR");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
design/fsnc_pkg.sv
design/fsnc_lane.sv
design/fsnc_merge.sv
design/fat_short_name_checker_core.sv
design/fsnc_checker.sv
sim/fat_short_name_checker_core_tb.sv
